// File: sv/llse_pkg.sv
// llse_pkg: shared types, constants and helpers for the lat/lon six-byte encoder
// no dependencies; used by scoped names in every other file of the block but llse_if
package llse_pkg;

  // angle units in sixteenths of an arc second, and the longitude degree multiplier
  localparam logic signed [23:0] LAT_SPAN = 24'sd5184000;
  localparam logic signed [23:0] LAT_MIN  = -24'sd5184000;
  localparam logic signed [26:0] TURN     = 27'sd20736000;
  localparam logic signed [26:0] NEG_TURN = -27'sd20736000;
  localparam logic signed [26:0] TURN2    = 27'sd41472000;
  localparam logic [24:0]        DEG_16THS = 25'd57600;
  localparam logic [15:0]        MIN_16THS = 16'd960;
  localparam logic [15:0]        LON_DEG_MULT = 16'd181;

  // reciprocal of 225 scaled by 2^24, exact for the degree quotient range
  localparam logic [33:0] DEG_RECIP = 34'd74566;
  // reciprocal of 15 scaled by 2^14, exact for the minute quotient range
  localparam logic [20:0] MIN_RECIP = 21'd1093;

  // load enables of the six pipeline stages
  typedef struct packed {
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } llse_en_t;

  // one angle split into its parts
  typedef struct packed {
    logic [8:0] deg;
    logic [5:0] mnt;
    logic [5:0] sec;
    logic [3:0] six;
  } llse_parts_t;

  // quotient and remainder of a seconds count by fifteen
  typedef struct packed {
    logic [1:0] q;
    logic [3:0] r;
  } llse_d15_t;

  function automatic llse_d15_t div15(input logic [5:0] s);
    llse_d15_t d;
    logic [5:0] r;
    if (s >= 6'd45) begin
      d.q = 2'd3;
      r = s - 6'd45;
    end else if (s >= 6'd30) begin
      d.q = 2'd2;
      r = s - 6'd30;
    end else if (s >= 6'd15) begin
      d.q = 2'd1;
      r = s - 6'd15;
    end else begin
      d.q = 2'd0;
      r = s;
    end
    d.r = r[3:0];
    return d;
  endfunction

endpackage

// File: sv/llse_if.sv
// llse_if: valid/ready channel interfaces for coordinate and code beats
// no dependencies
interface llse_in_if (input logic clk);
  logic              valid;
  logic              ready;
  logic signed [23:0] lat_sixteenths;
  logic signed [25:0] lon_sixteenths;

  modport source (output valid, output lat_sixteenths, output lon_sixteenths, input ready);
  modport sink (input valid, input lat_sixteenths, input lon_sixteenths, output ready);
endinterface

interface llse_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [47:0] code;

  modport source (output valid, output valid_res, output code, input ready);
  modport sink (input valid, input valid_res, input code, output ready);
endinterface

// File: sv/llse_prep.sv
// llse_prep: first stage, latitude range check and offset, longitude wrap, pole rule
// depends on llse_pkg
module llse_prep (
  input  logic                  clk,
  input  llse_pkg::llse_en_t    en,
  input  logic signed [23:0]    lat_sixteenths,
  input  logic signed [25:0]    lon_sixteenths,
  output logic                  ok,
  output logic [23:0]           la,
  output logic [24:0]           lo
);

  logic               in_range;
  logic               pole;
  logic signed [24:0] lat_off;
  logic signed [26:0] lon_x;
  logic signed [26:0] lon_w;

  // latitude checks and offset from the south pole
  assign in_range = (lat_sixteenths >= llse_pkg::LAT_MIN) &&
                    (lat_sixteenths <= llse_pkg::LAT_SPAN);
  assign pole     = (lat_sixteenths == llse_pkg::LAT_MIN) ||
                    (lat_sixteenths == llse_pkg::LAT_SPAN);
  assign lat_off  = {lat_sixteenths[23], lat_sixteenths} +
                    {llse_pkg::LAT_SPAN[23], llse_pkg::LAT_SPAN};

  // longitude into one turn; the field spans less than two turns each side
  assign lon_x = {lon_sixteenths[25], lon_sixteenths};
  always_comb begin
    if (lon_x < llse_pkg::NEG_TURN) begin
      lon_w = lon_x + llse_pkg::TURN2;
    end else if (lon_x < 27'sd0) begin
      lon_w = lon_x + llse_pkg::TURN;
    end else if (lon_x >= llse_pkg::TURN) begin
      lon_w = lon_x - llse_pkg::TURN;
    end else begin
      lon_w = lon_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ok <= in_range;
      la <= lat_off[23:0];
      lo <= pole ? 25'd0 : lon_w[24:0];
    end
  end

endmodule

// File: sv/llse_split.sv
// llse_split: four-stage split of one angle into degrees, minutes, seconds, sixteenths
// depends on llse_pkg
module llse_split (
  input  logic                  clk,
  input  llse_pkg::llse_en_t    en,
  input  logic [24:0]           a,
  output llse_pkg::llse_parts_t parts
);

  logic [24:0] a2;
  logic [33:0] p1;
  logic [8:0]  deg3;
  logic [8:0]  deg4;
  logic [15:0] r1;
  logic [15:0] r1_4;
  logic [20:0] p2;
  logic [24:0] r1_full;
  logic [15:0] r2;
  logic [5:0]  mnt_q;

  // stage 2: degrees by reciprocal of 225 on the angle over 256
  always_ff @(posedge clk) begin
    if (en.s2) begin
      a2 <= a;
      p1 <= 34'(a[24:8]) * llse_pkg::DEG_RECIP;
    end
  end

  // stage 3: degree quotient and remainder within the degree
  assign r1_full = a2 - 25'(p1[32:24]) * llse_pkg::DEG_16THS;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      deg3 <= p1[32:24];
      r1   <= r1_full[15:0];
    end
  end

  // stage 4: minutes by reciprocal of 15 on the remainder over 64
  always_ff @(posedge clk) begin
    if (en.s4) begin
      deg4 <= deg3;
      r1_4 <= r1;
      p2   <= 21'(r1[15:6]) * llse_pkg::MIN_RECIP;
    end
  end

  // stage 5: minute quotient, seconds and sixteenths
  assign mnt_q = p2[19:14];
  assign r2    = r1_4 - 16'(mnt_q) * llse_pkg::MIN_16THS;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      parts.deg <= deg4;
      parts.mnt <= mnt_q;
      parts.sec <= r2[9:4];
      parts.six <= r2[3:0];
    end
  end

endmodule

// File: sv/llse_pack.sv
// llse_pack: last stage, degree combine and byte packing into the 48-bit code
// depends on llse_pkg
module llse_pack (
  input  logic                  clk,
  input  llse_pkg::llse_en_t    en,
  input  logic                  ok,
  input  llse_pkg::llse_parts_t lat_p,
  input  llse_pkg::llse_parts_t lon_p,
  output logic                  valid_res,
  output logic [47:0]           code
);

  logic [15:0]         dd;
  llse_pkg::llse_d15_t lat_s;
  llse_pkg::llse_d15_t lon_s;
  logic [7:0]          b2;
  logic [7:0]          b3;
  logic [7:0]          b4;
  logic [7:0]          b5;

  // both degree counts into one 16-bit field
  assign dd = 16'(lat_p.deg) + 16'(lon_p.deg) * llse_pkg::LON_DEG_MULT;

  // seconds into quarter minutes and remainder
  assign lat_s = llse_pkg::div15(lat_p.sec);
  assign lon_s = llse_pkg::div15(lon_p.sec);

  assign b2 = {lat_p.mnt[5:2], lon_p.mnt[5:2]};
  assign b3 = {lat_p.mnt[1:0], lon_p.mnt[1:0], lat_s.q, lon_s.q};
  assign b4 = {lat_s.r, lon_s.r};
  assign b5 = {lat_p.six, lon_p.six};

  // output register, code cleared for an out-of-range latitude
  always_ff @(posedge clk) begin
    if (en.s6) begin
      valid_res <= ok;
      code      <= ok ? {dd, b2, b3, b4, b5} : 48'd0;
    end
  end

endmodule

// File: sv/latlon_six_byte_encoder.sv
// latlon_six_byte_encoder: top level, six-stage pipeline from coordinate pair to code
// depends on llse_pkg, llse_if, llse_prep, llse_split, llse_pack
//
//   channel  dir  fields                              beat taken when
//   coord    in   lat_sixteenths, lon_sixteenths      coord.valid & coord.ready
//   result   out  valid_res, code                     result.valid & result.ready
//
// one coordinate pair a cycle unless result is stalled and the pipeline is full
// stages: wrap, degree multiply, degree remainder, minute multiply, seconds, pack
// each stage loads when empty or when the stage after it moves, so bubbles close up
// coord.ready falls only when all six stages hold a beat and result is stalled
// rst clears the stage valid bits; data registers carry no reset
module latlon_six_byte_encoder (
  input logic        clk,
  input logic        rst,
  llse_in_if.sink    coord,
  llse_out_if.source result
);

  logic [6:1]            v;
  logic [7:1]            en_v;
  llse_pkg::llse_en_t    en;
  logic                  ok1;
  logic                  ok2;
  logic                  ok3;
  logic                  ok4;
  logic                  ok5;
  logic [23:0]           la;
  logic [24:0]           lo;
  llse_pkg::llse_parts_t lat_p;
  llse_pkg::llse_parts_t lon_p;

  // stage load enables, from the output back to the input
  always_comb begin
    en_v[7] = result.ready;
    for (int k = 6; k >= 1; k--) begin
      en_v[k] = !v[k] || en_v[k + 1];
    end
  end
  assign en          = llse_pkg::llse_en_t'(en_v[6:1]);
  assign coord.ready = en_v[1];
  assign result.valid = v[6];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en_v[1]) begin
        v[1] <= coord.valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en_v[k]) begin
          v[k] <= v[k - 1];
        end
      end
    end
  end

  // range flag alongside the split stages
  always_ff @(posedge clk) begin
    if (en.s2) begin
      ok2 <= ok1;
    end
    if (en.s3) begin
      ok3 <= ok2;
    end
    if (en.s4) begin
      ok4 <= ok3;
    end
    if (en.s5) begin
      ok5 <= ok4;
    end
  end

  llse_prep u_prep (
    .clk            (clk),
    .en             (en),
    .lat_sixteenths (coord.lat_sixteenths),
    .lon_sixteenths (coord.lon_sixteenths),
    .ok             (ok1),
    .la             (la),
    .lo             (lo)
  );

  llse_split u_split_lat (
    .clk   (clk),
    .en    (en),
    .a     ({1'b0, la}),
    .parts (lat_p)
  );

  llse_split u_split_lon (
    .clk   (clk),
    .en    (en),
    .a     (lo),
    .parts (lon_p)
  );

  llse_pack u_pack (
    .clk       (clk),
    .en        (en),
    .ok        (ok5),
    .lat_p     (lat_p),
    .lon_p     (lon_p),
    .valid_res (result.valid_res),
    .code      (result.code)
  );

`ifndef SYNTHESIS
  // an invalid result never carries a code
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.valid_res) |-> (result.code == 48'd0))
    else $error("invalid result with non-zero code");

  // pipeline occupancy changes only through the two handshakes
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    ((coord.valid && coord.ready) == (result.valid && result.ready)) |=>
      ($countones(v) == $past($countones(v))))
    else $error("beat lost or repeated inside the pipeline");

  // input back-pressure only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !coord.ready |-> ((v == 6'b111111) && !result.ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: tb/sv/tb.sv
// tb: self-checking bench for latlon_six_byte_encoder, random and corner coordinate beats
// depends on llse_pkg, llse_if and latlon_six_byte_encoder; results are predicted in the bench and compared in order
// both channels idle and stall at random, with quiet stretches in between
module tb;

  localparam longint LAT_HALF  = 64'sd5184000;
  localparam longint LON_TURN  = 64'sd20736000;
  localparam longint DEG_UNITS = 64'sd57600;
  localparam longint MIN_UNITS = 64'sd960;
  localparam longint DEG_MULT  = 64'sd181;
  localparam int     N_RANDOM  = 850;

  typedef struct {
    logic signed [23:0] lat;
    logic signed [25:0] lon;
    logic               valid_res;
    logic [47:0]        code;
  } code_exp_t;

  // expected codes, in acceptance order
  class code_checker;
    code_exp_t pending_codes[$];
    int        fails;

    function new();
      fails = 0;
    endfunction

    function automatic llse_pkg::llse_parts_t split_angle(longint a);
      llse_pkg::llse_parts_t p;
      p.deg = 9'(a / DEG_UNITS);
      a = a % DEG_UNITS;
      p.mnt = 6'(a / MIN_UNITS);
      a = a % MIN_UNITS;
      p.sec = 6'(a / 16);
      p.six = 4'(a % 16);
      return p;
    endfunction

    // the code a coordinate pair should give
    function automatic code_exp_t encode_pair(logic signed [23:0] lat,
                                              logic signed [25:0] lon);
      code_exp_t             e;
      longint                la;
      longint                lo;
      llse_pkg::llse_parts_t pa;
      llse_pkg::llse_parts_t po;
      logic [15:0]           dd;
      e.lat = lat;
      e.lon = lon;
      e.valid_res = 1'b0;
      e.code = '0;
      if (longint'(lat) < -LAT_HALF || longint'(lat) > LAT_HALF) return e;
      la = longint'(lat) + LAT_HALF;
      // at either pole the longitude carries no meaning
      if (la == 0 || la == 2 * LAT_HALF) begin
        lo = 0;
      end else begin
        lo = longint'(lon) % LON_TURN;
        if (lo < 0) lo += LON_TURN;
      end
      pa = split_angle(la);
      po = split_angle(lo);
      dd = 16'(longint'(pa.deg) + longint'(po.deg) * DEG_MULT);
      e.valid_res = 1'b1;
      e.code = {dd,
                4'(pa.mnt / 4), 4'(po.mnt / 4),
                2'(pa.mnt % 4), 2'(po.mnt % 4), 2'(pa.sec / 15), 2'(po.sec / 15),
                4'(pa.sec % 15), 4'(po.sec % 15),
                pa.six, po.six};
      return e;
    endfunction

    task report_mismatch(string what);
      if (fails < 40) $display("[%0t] mismatch: %s", $realtime, what);
      fails++;
    endtask

    function void note_pair(logic signed [23:0] lat, logic signed [25:0] lon);
      pending_codes.push_back(encode_pair(lat, lon));
    endfunction

    task check_code(logic valid_res, logic [47:0] code);
      code_exp_t e;
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, valid_res %b code %h",
                                  valid_res, code));
      end else begin
        e = pending_codes.pop_front();
        if (valid_res !== e.valid_res)
          report_mismatch($sformatf("lat %0d lon %0d: valid_res %b, want %b",
                                    e.lat, e.lon, valid_res, e.valid_res));
        if (code !== e.code)
          report_mismatch($sformatf("lat %0d lon %0d: code %h, want %h",
                                    e.lat, e.lon, code, e.code));
      end
    endtask

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;

  llse_in_if  coord_if (clk);
  llse_out_if res_if (clk);

  latlon_six_byte_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .coord  (coord_if),
    .result (res_if)
  );

  code_checker codes = new();

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // mostly short gaps, a few long, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [23:0] rand_lat();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 75) return 24'(int'($urandom_range(0, 10368000)) - 5184000);
    if (r < 87) begin
      // poles and the edges of the valid span
      k = $urandom_range(0, 2);
      return ($urandom_range(0, 1) ? 24'sd5184000 : -24'sd5184000) +
             ($urandom_range(0, 1) ? 24'(k) : -24'(k));
    end
    return 24'($urandom);
  endfunction

  function automatic logic signed [25:0] rand_lon();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 26'(int'($urandom_range(0, 41472000)) - 20736000);
    if (r < 88)
      return 26'(int'($urandom_range(0, 2)) * 20736000 - 20736000 +
                 int'($urandom_range(0, 6)) - 3);
    return 26'($urandom);
  endfunction

  // one coordinate beat, after a gap
  task drive_coord(logic signed [23:0] lat, logic signed [25:0] lon, int gap);
    repeat (gap) begin
      @(negedge clk);
      coord_if.valid <= 1'b0;
    end
    @(negedge clk);
    coord_if.valid <= 1'b1;
    coord_if.lat_sixteenths <= lat;
    coord_if.lon_sixteenths <= lon;
    do @(posedge clk); while (!coord_if.ready);
    codes.note_pair(lat, lon);
  endtask

  // result side back-pressure
  task drive_ready();
    int hi;
    int lo;
    forever begin
      hi = $urandom_range(1, 20);
      lo = pick_gap();
      repeat (hi) begin
        @(negedge clk);
        res_if.ready <= 1'b1;
      end
      repeat (lo) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
    end
  endtask

  // result beats
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      codes.check_code(res_if.valid_res, res_if.code);
  end

  // corner pairs: zero, poles, out of range, wraps, field extremes, part boundaries
  logic signed [23:0] corner_lat[20] = '{
    24'sd0, -24'sd5184000, 24'sd5184000, -24'sd5184001, 24'sd5184001,
    24'sh800000, 24'sd8388607, 24'sd5183999, -24'sd5183999, 24'sd1,
    -24'sd1, 24'sd0, 24'sd0, -24'sd5126401, 24'sd57599,
    24'sd224, 24'sd719, 24'sd2880, -24'sd2, 24'sd4194303
  };
  logic signed [25:0] corner_lon[20] = '{
    26'sd0, 26'sd12345, -26'sd777, 26'sd100, 26'sd0,
    26'sh2000000, 26'sd33554431, 26'sd20735999, -26'sd1, 26'sd20736000,
    -26'sd20736000, 26'sd33554431, 26'sh2000000, 26'sd57599, 26'sd20735999,
    26'sd240, 26'sd720, 26'sd3840, 26'sd2, -26'sd16777216
  };

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    coord_if.valid = 1'b0;
    coord_if.lat_sixteenths = '0;
    coord_if.lon_sixteenths = '0;
    res_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      drive_ready();
    join_none

    foreach (corner_lat[i]) drive_coord(corner_lat[i], corner_lon[i], pick_gap());

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      drive_coord(rand_lat(), rand_lon(), pick_gap());
    end
    @(negedge clk);
    coord_if.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (codes.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (codes.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
